// ===== design/hjt_pkg.sv =====
// Package for the hash join table: shared word types, the queued command
// format, status and kind codes, and the count clamp.
// No dependencies.
package hjt_pkg;

  localparam int WORD_W    = 64;
  localparam int WORDS     = 4;
  localparam int BKT_W_MAX = 16;
  localparam int ROW_W     = 2 * WORDS * WORD_W;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_MATCH    = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_PROBE  = 1'b1
  } kind_e;

  // Configuration register indexes.
  localparam logic CFG_KEY_COUNT     = 1'b0;
  localparam logic CFG_PAYLOAD_COUNT = 1'b1;

  typedef logic [WORDS-1:0][WORD_W-1:0] words_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    kind_e                kind;
    logic [BKT_W_MAX-1:0] bucket;
    words_t               keys;
    words_t               pays;
  } cmd_t;

  // Counts above four act as four.
  function automatic logic [2:0] clamp_count(input logic [2:0] c);
    return (c > 3'd4) ? 3'd4 : c;
  endfunction

endpackage

// ===== design/hjt_front.sv =====
// Front end of the hash join table: accepts input transfers and reduces the
// hash to a bucket number, eight hash bits per cycle.
// Depends on hjt_pkg.
module hjt_front #(
  parameter int BUCKET_CNT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [575:0]  s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          enable_i,
  output logic          q_push_o,
  output hjt_pkg::cmd_t q_cmd_o,
  input  logic          q_full_i
);
  import hjt_pkg::*;

  localparam int BW = $clog2(BUCKET_CNT);
  localparam int RW = BW + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [63:0] hash_q, hash_d;
  kind_e       kind_q;
  words_t      keys_q, pays_q;
  logic [BW-1:0] rem_q, rem_d;
  logic [2:0]  step_q, step_d;
  logic        accept;

  assign s_axis_tready = (state_q == F_IDLE) && enable_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Remainder of the hash by the bucket count, most significant bits first.
  always_comb begin
    logic [RW-1:0] t;
    logic [BW-1:0] r;
    r = rem_q;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, hash_q[63-i]};
      if (t >= RW'(BUCKET_CNT)) begin
        t = t - RW'(BUCKET_CNT);
      end
      r = t[BW-1:0];
    end
    rem_d = r;
  end

  // Sequencing of accept, reduce and hand-off.
  always_comb begin
    state_d  = state_q;
    hash_d   = hash_q;
    step_d   = step_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          hash_d  = s_axis_tdata[63:0];
          step_d  = '0;
          state_d = F_MOD;
        end
      end
      F_MOD: begin
        hash_d = {hash_q[55:0], 8'h00};
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Item payload and the running remainder.
  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (accept) begin
      kind_q <= kind_e'(s_axis_tuser);
      keys_q <= s_axis_tdata[319:64];
      pays_q <= s_axis_tdata[575:320];
      rem_q  <= '0;
    end else if (state_q == F_MOD) begin
      rem_q <= rem_d;
    end
  end

  assign q_cmd_o.kind   = kind_q;
  assign q_cmd_o.bucket = BKT_W_MAX'(rem_q);
  assign q_cmd_o.keys   = keys_q;
  assign q_cmd_o.pays   = pays_q;

endmodule

// ===== design/hjt_queue.sv =====
// Short command queue between the front and the back of the hash join table.
// Depends on hjt_pkg.
module hjt_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hjt_pkg::cmd_t data_i,
  input  logic          pop_i,
  output hjt_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import hjt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          store_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = store_q[rd_q];

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/hjt_back.sv =====
// Back end of the hash join table: bucket fill memory, entry memory, insert
// and probe sequencing, and the result register.
// Depends on hjt_pkg.
module hjt_back #(
  parameter int BUCKET_CNT   = 256,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hjt_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          init_done_o,
  input  logic [2:0]    key_count_i,
  input  logic [2:0]    payload_count_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [511:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,
  output logic          m_axis_tlast
);
  import hjt_pkg::*;

  localparam int BW    = $clog2(BUCKET_CNT);
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOTS = BUCKET_CNT * BUCKET_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  typedef enum logic [5:0] {
    B_CLR  = 6'b000001,
    B_IDLE = 6'b000010,
    B_EXEC = 6'b000100,
    B_RD   = 6'b001000,
    B_CMP  = 6'b010000,
    B_FIN  = 6'b100000
  } bstate_e;

  bstate_e          state_q, state_d;
  cmd_t             cmd_q;
  logic [BW-1:0]    clr_q;
  logic [FW-1:0]    slot_q, slot_d;
  logic             pend_v_q, pend_v_d;
  logic [ROW_W-1:0] pend_q;
  logic             pend_ld;

  logic [FW-1:0]    fill_mem [BUCKET_CNT];
  logic [FW-1:0]    fill_rd_q;
  logic             fill_we;
  logic [BW-1:0]    fill_waddr;
  logic [FW-1:0]    fill_wdata;

  logic [ROW_W-1:0] entry_mem [SLOTS];
  logic [ROW_W-1:0] ent_rd_q;
  logic             ent_we, ent_re;
  logic [AW-1:0]    ent_addr;
  logic [ROW_W-1:0] ent_wdata;

  logic             out_v_q;
  status_e          out_status_q;
  logic [ROW_W-1:0] out_data_q;
  logic             out_last_q;
  logic             out_free, push, push_last;
  status_e          push_status;
  logic [ROW_W-1:0] push_row, push_masked;

  logic [2:0]       nk, np;
  logic [BW-1:0]    bkt;
  logic             hit;

  assign nk       = clamp_count(key_count_i);
  assign np       = clamp_count(payload_count_i);
  assign bkt      = cmd_q.bucket[BW-1:0];
  assign out_free = !out_v_q || m_axis_tready;
  assign init_done_o = (state_q != B_CLR);

  // Slot address inside the entry memory.
  always_comb begin
    logic [FW-1:0] s;
    s = (state_q == B_EXEC) ? fill_rd_q : slot_q;
    ent_addr = AW'(bkt) * AW'(BUCKET_DEPTH) + AW'(s);
  end

  // Stored row of an insert; words beyond the counts are kept as zero.
  always_comb begin
    ent_wdata = '0;
    for (int i = 0; i < WORDS; i++) begin
      if (i < int'(nk)) begin
        ent_wdata[i*WORD_W +: WORD_W] = cmd_q.keys[i];
      end
      if (i < int'(np)) begin
        ent_wdata[(WORDS+i)*WORD_W +: WORD_W] = cmd_q.pays[i];
      end
    end
  end

  // Compare the leading key words of the slot just read.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < WORDS; i++) begin
      if (i < int'(nk) && ent_rd_q[i*WORD_W +: WORD_W] != cmd_q.keys[i]) begin
        hit = 1'b0;
      end
    end
  end

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    pend_v_d    = pend_v_q;
    pend_ld     = 1'b0;
    pop_o       = 1'b0;
    fill_we     = 1'b0;
    fill_waddr  = bkt;
    fill_wdata  = '0;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    push        = 1'b0;
    push_status = ST_INSERTED;
    push_row    = '0;
    push_last   = 1'b1;
    case (state_q)
      B_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        if (clr_q == BW'(BUCKET_CNT - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cmd_q.kind == KIND_INSERT) begin
          if (out_free) begin
            push    = 1'b1;
            state_d = B_IDLE;
            if (fill_rd_q < FW'(BUCKET_DEPTH)) begin
              ent_we      = 1'b1;
              fill_we     = 1'b1;
              fill_wdata  = fill_rd_q + FW'(1);
              push_status = ST_INSERTED;
            end else begin
              push_status = ST_FULL;
            end
          end
        end else if (fill_rd_q == '0) begin
          state_d = B_FIN;
        end else begin
          slot_d  = '0;
          state_d = B_RD;
        end
      end
      B_RD: begin
        ent_re  = 1'b1;
        state_d = B_CMP;
      end
      B_CMP: begin
        if (!(hit && pend_v_q && !out_free)) begin
          if (hit) begin
            push        = pend_v_q;
            push_status = ST_MATCH;
            push_row    = pend_q;
            push_last   = 1'b0;
            pend_ld     = 1'b1;
            pend_v_d    = 1'b1;
          end
          slot_d  = slot_q + FW'(1);
          state_d = (slot_q + FW'(1) == fill_rd_q) ? B_FIN : B_RD;
        end
      end
      B_FIN: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = pend_v_q ? ST_MATCH : ST_NO_MATCH;
          push_row    = pend_v_q ? pend_q : '0;
          pend_v_d    = 1'b0;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Result words beyond the current counts read zero.
  always_comb begin
    push_masked = '0;
    for (int i = 0; i < WORDS; i++) begin
      if (i < int'(nk)) begin
        push_masked[i*WORD_W +: WORD_W] = push_row[i*WORD_W +: WORD_W];
      end
      if (i < int'(np)) begin
        push_masked[(WORDS+i)*WORD_W +: WORD_W] = push_row[(WORDS+i)*WORD_W +: WORD_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_CLR;
      clr_q    <= '0;
      slot_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      pend_v_q <= pend_v_d;
      if (state_q == B_CLR) begin
        clr_q <= clr_q + BW'(1);
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Command, pending match and result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (pend_ld) begin
      pend_q <= ent_rd_q;
    end
    if (push) begin
      out_status_q <= push_status;
      out_data_q   <= push_masked;
      out_last_q   <= push_last;
    end
  end

  // Bucket fill memory, read registered.
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (pop_o) begin
      fill_rd_q <= fill_mem[head_i.bucket[BW-1:0]];
    end
  end

  // Entry memory, one row per slot, read registered.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_addr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= entry_mem[ent_addr];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE |-> !pend_v_q)
    else $error("pending match left over between items");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> fill_wdata <= FW'(BUCKET_DEPTH))
    else $error("bucket fill written beyond bucket depth");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result register overwritten before transfer");

endmodule

// ===== design/hash_join_table.sv =====
// Top level of the hash join build and probe table.
// Depends on hjt_pkg, hjt_front, hjt_queue and hjt_back.
//
// Channel   Direction  Content
// s_axis    in         tuser kind; tdata hash, keys 0-3, payloads 0-3
// m_axis    out        tuser status; tdata keys 0-3, payloads 0-3; tlast
// cfg       in         index 0 key_count, index 1 payload_count, 3-bit data
//
// The front takes one item at a time and accepts the next only after handing
// the last to the queue; it reduces the hash to a bucket, eight bits per
// cycle. The back reads each stored slot of a probed bucket in turn, one
// entry memory read each. After reset the fill memory is cleared, during
// which s_axis_tready stays low. A two-entry queue lets the front run ahead
// while the back waits on m_axis_tready.
module hash_join_table #(
  parameter int BUCKET_CNT   = 256,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [575:0] s_axis_tdata,   // hash, key_0..3, payload_0..3
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [511:0] m_axis_tdata,   // match_key_0..3, match_payload_0..3
  output logic [1:0]   m_axis_tuser,   // status
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [2:0]   cfg_data_i
);
  import hjt_pkg::*;

  logic [2:0] kc_q, pc_q;
  logic       q_push, q_pop, q_full, q_empty, init_done;
  cmd_t       q_in, q_head;

  assign cfg_ready_o  = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q <= 3'd1;
      pc_q <= 3'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY_COUNT:     kc_q <= cfg_data_i;
        CFG_PAYLOAD_COUNT: pc_q <= cfg_data_i;
        default:           kc_q <= kc_q;
      endcase
    end
  end

  hjt_front #(.BUCKET_CNT(BUCKET_CNT)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .enable_i (init_done),
    .q_push_o (q_push),
    .q_cmd_o  (q_in),
    .q_full_i (q_full)
  );

  hjt_queue #(.DEPTH(2)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hjt_back #(.BUCKET_CNT(BUCKET_CNT), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .head_i          (q_head),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .init_done_o     (init_done),
    .key_count_i     (kc_q),
    .payload_count_i (pc_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule
